>>> rtl/core/integer_to_ascii_radix_formatter_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII radix formatter
// Concurrent checks that compile away when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_FORMATTER_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_FORMATTER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define I2A_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define I2A_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define I2A_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define I2A_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/core/i2a_fmt_pkg.sv
// ----------------------------------------------------------------------------
// Integer to ASCII radix formatter package
// Radix codes, sequencer states, character constants and a digit to ASCII function
// ----------------------------------------------------------------------------
package i2a_fmt_pkg;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_BIN = 2'd1,
      RADIX_HEX = 2'd2,
      RADIX_OCT = 2'd3
   } radix_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DABBLE = 5'b00010,
      ST_SKIP   = 5'b00100,
      ST_SIGN   = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;

   function automatic logic [7:0] digit_char(input logic [3:0] digit);
      logic [7:0] ch;
      case (digit)
         4'hA: ch = 8'h41;
         4'hB: ch = 8'h42;
         4'hC: ch = 8'h43;
         4'hD: ch = 8'h44;
         4'hE: ch = 8'h45;
         4'hF: ch = 8'h46;
         default: ch = CHAR_ZERO + {4'h0, digit};
      endcase
      return ch;
   endfunction

endpackage

>>> rtl/core/integer_to_ascii_radix_formatter_top.sv
// ----------------------------------------------------------------------------
// Integer to ASCII radix formatter
// Turns one integer into its text in decimal, grouped binary, hex or octal
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  request   req_valid req_stall req_value           in
//  response  rsp_valid rsp_stall rsp_out_char/last   out
//  csr       csr_wr_en csr_output_radix              in
//
//  digits come from a bit-serial double dabble, and at width 32 leading
//  zero digits leave a 48-bit shift register one per cycle
//  a new request is taken the cycle after the last character is loaded
//  reset clears the sequencer, output valid and the radix (decimal)
//  rsp_stall holds the output register and pauses character generation
`include "integer_to_ascii_radix_formatter_top_assert.svh"

module integer_to_ascii_radix_formatter_top #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_char,
   output logic                          rsp_last_char,
   input  logic                          csr_wr_en,
   input  logic [1:0]                    csr_output_radix
);
   import i2a_fmt_pkg::*;

   localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_W      = 4 * DEC_DIGITS;
   localparam int VAL_PAD_W  = ((VALUE_WIDTH + 11) / 12) * 12;
   localparam int BCD_PAD_W  = ((BCD_W + 11) / 12) * 12;
   localparam int SR_W       = (VAL_PAD_W > BCD_PAD_W) ? VAL_PAD_W : BCD_PAD_W;
   localparam int NIBBLES    = SR_W / 4;
   localparam int OCTETS     = SR_W / 3;
   localparam int CNT_W      = $clog2(SR_W + 1);

   state_type              state_ff, state_in;
   radix_type              radix_ff, radix_in;
   logic [SR_W-1:0]        sr_ff, sr_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic                   space_ff, space_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [VALUE_WIDTH-1:0] value_u;
   logic                   req_take;
   logic                   out_free;
   logic [SR_W-1:0]        sr_adj;
   logic [3:0]             top_digit;
   logic [CNT_W-1:0]       cnt_dec;

   assign value_u   = $unsigned(req_value);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign top_digit = (radix_ff == RADIX_OCT) ? {1'b0, sr_ff[SR_W-1 -: 3]}
                                              : sr_ff[SR_W-1 -: 4];
   assign cnt_dec   = cnt_ff - CNT_W'(1);

   // add-3 on every bcd digit of 5 or more before the shift
   always_comb begin
      logic [3:0] nib;
      sr_adj = sr_ff;
      for (int i = 0; i < NIBBLES; i++) begin
         nib = sr_ff[4*i +: 4];
         sr_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
   end

   always_comb begin
      state_in     = state_ff;
      radix_in     = radix_ff;
      sr_in        = sr_ff;
      mag_in       = mag_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      space_in     = space_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_wr_en) begin
         radix_in = radix_type'(csr_output_radix);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               neg_in   = (radix_ff == RADIX_DEC) && value_u[VALUE_WIDTH-1];
               mag_in   = value_u[VALUE_WIDTH-1] ? (~value_u + VALUE_WIDTH'(1)) : value_u;
               space_in = 1'b0;
               if (radix_ff == RADIX_DEC) begin
                  sr_in    = '0;
                  cnt_in   = CNT_W'(VALUE_WIDTH);
                  state_in = ST_DABBLE;
               end else begin
                  sr_in    = SR_W'(value_u);
                  cnt_in   = (radix_ff == RADIX_OCT) ? CNT_W'(OCTETS) : CNT_W'(NIBBLES);
                  state_in = ST_SKIP;
               end
            end
         end
         ST_DABBLE: begin
            sr_in  = {sr_adj[SR_W-2:0], mag_ff[VALUE_WIDTH-1]};
            mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in = cnt_dec;
            if (cnt_ff == CNT_W'(1)) begin
               cnt_in   = CNT_W'(NIBBLES);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit == 4'd0 && cnt_ff != CNT_W'(1)) begin
               sr_in  = (radix_ff == RADIX_OCT) ? (sr_ff << 3) : (sr_ff << 4);
               cnt_in = cnt_dec;
            end else begin
               if (radix_ff == RADIX_BIN) begin
                  cnt_in = cnt_ff << 2;
               end
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               if (radix_ff == RADIX_BIN) begin
                  if (space_ff) begin
                     rsp_char_in = CHAR_SPACE;
                     space_in    = 1'b0;
                  end else begin
                     rsp_char_in = sr_ff[SR_W-1] ? CHAR_ONE : CHAR_ZERO;
                     sr_in       = sr_ff << 1;
                     cnt_in      = cnt_dec;
                     space_in    = (cnt_dec != '0) && (cnt_dec[1:0] == 2'b00);
                     rsp_last_in = (cnt_ff == CNT_W'(1));
                  end
               end else begin
                  rsp_char_in = digit_char(top_digit);
                  sr_in       = (radix_ff == RADIX_OCT) ? (sr_ff << 3) : (sr_ff << 4);
                  cnt_in      = cnt_dec;
                  rsp_last_in = (cnt_ff == CNT_W'(1));
               end
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_DEC;
         rsp_valid_ff <= 1'b0;
         space_ff     <= 1'b0;
         cnt_ff       <= '0;
         neg_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
         space_ff     <= space_in;
         cnt_ff       <= cnt_in;
         neg_ff       <= neg_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff       <= sr_in;
      mag_ff      <= mag_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

   `I2A_ASSERT_SAME(a_state_onehot, clock, reset, 1'b1, $onehot(state_ff),
                    "state not one-hot")
   `I2A_ASSERT_SAME(a_cnt_busy, clock, reset, state_ff != ST_IDLE, cnt_ff != '0,
                    "busy with zero count")
   `I2A_ASSERT_SAME(a_space_pos, clock, reset, space_ff && state_ff == ST_EMIT,
                    (cnt_ff != '0) && (cnt_ff[1:0] == 2'b00), "space off group boundary")
   `I2A_ASSERT_NEXT(a_dec_start, clock, reset, req_take && radix_ff == RADIX_DEC,
                    state_ff == ST_DABBLE, "decimal request skipped conversion")
   `I2A_ASSERT_SAME(a_sign_dec, clock, reset, state_ff == ST_SIGN, radix_ff == RADIX_DEC,
                    "sign outside decimal")

endmodule
